// ===== rtl/srlp_pkg.sv =====
// Shared types and constants for the S-record line parser.
// Holds character codes, status codes, the parser phase type and the result record.
// No dependencies.
package srlp_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_F       = 8'h46;

  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_FORMAT   = 4'd1;
  localparam logic [3:0] ST_CHECKSUM = 4'd2;
  localparam logic [3:0] ST_BYTECNT  = 4'd3;
  localparam logic [3:0] ST_END      = 4'd4;
  localparam logic [3:0] ST_SKIPPED  = 4'd5;
  localparam logic [3:0] ST_S4       = 4'd6;
  localparam logic [3:0] ST_HDR_OK   = 4'd7;
  localparam logic [3:0] ST_HDR_MISS = 4'd8;

  localparam logic [3:0] REC_S4      = 4'd4;
  localparam logic [3:0] REC_S7      = 4'd7;

  typedef enum logic [7:0] {
    PH_START = 8'b0000_0001,
    PH_TYPE  = 8'b0000_0010,
    PH_COUNT = 8'b0000_0100,
    PH_ADDR  = 8'b0000_1000,
    PH_DATA  = 8'b0001_0000,
    PH_CSUM  = 8'b0010_0000,
    PH_EOL   = 8'b0100_0000,
    PH_SKIP  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic [3:0]  line_status;
    logic [3:0]  record_digit;
  } res_t;

endpackage

// ===== rtl/srecord_line_parser_top.sv =====
// S-record line parser, top level: character FSM, byte decode and output skid buffer.
// Depends on srlp_pkg.
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid, in_stall, in_char_in, in_end_of_input    | in
//  out     | out_valid, out_stall, out_kind, out_data_byte,     | out
//          | out_byte_address, out_line_status, out_record_digit|
//
// One character is taken per cycle while in_stall is low; its result, if any, enters
// the result register, or the skid entry while that register is held. Rate is set by the
// single parser state update and a 32-bit address add ahead of the result register.
// A two-entry output buffer (result register plus skid) takes requests while a result
// waits; in_stall rises only when both entries are full.
// rst_n is synchronous, active low; it puts the parser at line start of a new file.
module srecord_line_parser_top
  import srlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_byte_address,
  output logic [3:0]  out_line_status,
  output logic [3:0]  out_record_digit
);

  phase_t      phase_r, phase_nxt;
  logic        first_line_r, first_line_nxt;
  logic [3:0]  type_digit_r, type_digit_nxt;
  logic [2:0]  address_bytes_r, address_bytes_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic        nibble_half_r, nibble_half_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  fields_left_r, fields_left_nxt;
  logic [31:0] address_accum_r, address_accum_nxt;
  logic [7:0]  data_index_r, data_index_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [3:0]  pending_status_r, pending_status_nxt;

  logic        in_acc;
  logic        emit;
  res_t        res;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [7:0]  byte_val;
  logic [7:0]  sum_add;
  logic [7:0]  fields_dec;
  logic [3:0]  end_st;
  logic [3:0]  digit;

  res_t        out_r;
  logic        out_valid_r;
  res_t        skid_r;
  logic        skid_valid_r;
  logic        out_fire;
  logic        res_valid;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = in_char_in[3:0];
    if (in_char_in >= CH_ZERO && in_char_in <= CH_NINE) begin
      hex_val = in_char_in[3:0];
    end else if (in_char_in >= CH_A && in_char_in <= CH_F) begin
      hex_val = in_char_in[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign byte_val   = {high_nibble_r, hex_val};
  assign sum_add    = running_sum_r + byte_val;
  assign fields_dec = fields_left_r - 8'd1;
  assign digit      = in_char_in[3:0];

  always_comb begin
    if (phase_r == PH_SKIP) begin
      end_st = pending_status_r;
    end else if (phase_r == PH_EOL) begin
      end_st = ST_OK;
    end else begin
      end_st = first_line_r ? ST_HDR_MISS : ST_FORMAT;
    end
  end

  always_comb begin
    phase_nxt          = phase_r;
    first_line_nxt     = first_line_r;
    type_digit_nxt     = type_digit_r;
    address_bytes_nxt  = address_bytes_r;
    high_nibble_nxt    = high_nibble_r;
    nibble_half_nxt    = nibble_half_r;
    byte_count_nxt     = byte_count_r;
    fields_left_nxt    = fields_left_r;
    address_accum_nxt  = address_accum_r;
    data_index_nxt     = data_index_r;
    running_sum_nxt    = running_sum_r;
    pending_status_nxt = pending_status_r;
    emit               = 1'b0;
    res.kind           = KIND_STATUS;
    res.data_byte      = 8'd0;
    res.byte_address   = 32'd0;
    res.line_status    = end_st;
    res.record_digit   = type_digit_r;

    if (in_end_of_input || in_char_in == CH_NEWLINE) begin
      // close the line: report it (at end of input only if begun or on the first line), then clear per-line state
      emit = in_end_of_input ? (phase_r != PH_START || first_line_r) : 1'b1;
      phase_nxt          = PH_START;
      first_line_nxt     = in_end_of_input;
      type_digit_nxt     = 4'd0;
      address_bytes_nxt  = 3'd0;
      high_nibble_nxt    = 4'd0;
      nibble_half_nxt    = 1'b0;
      byte_count_nxt     = 8'd0;
      fields_left_nxt    = 8'd0;
      address_accum_nxt  = 32'd0;
      data_index_nxt     = 8'd0;
      running_sum_nxt    = 8'd0;
      pending_status_nxt = ST_OK;
    end else begin
      case (phase_r)
        PH_START: begin
          if (in_char_in == CH_S) begin
            phase_nxt = PH_TYPE;
          end else begin
            phase_nxt          = PH_SKIP;
            pending_status_nxt = first_line_r ? ST_HDR_MISS : ST_FORMAT;
          end
        end
        PH_TYPE: begin
          if (in_char_in < CH_ZERO || in_char_in > CH_NINE) begin
            phase_nxt          = PH_SKIP;
            pending_status_nxt = first_line_r ? ST_HDR_MISS : ST_FORMAT;
          end else begin
            type_digit_nxt = digit;
            if (first_line_r) begin
              phase_nxt          = PH_SKIP;
              pending_status_nxt = (digit == 4'd0) ? ST_HDR_OK : ST_HDR_MISS;
            end else if (digit >= 4'd1 && digit <= 4'd3) begin
              address_bytes_nxt = in_char_in[2:0] + 3'd1;
              nibble_half_nxt   = 1'b0;
              running_sum_nxt   = 8'd0;
              phase_nxt         = PH_COUNT;
            end else if (digit >= REC_S7) begin
              phase_nxt          = PH_SKIP;
              pending_status_nxt = ST_END;
            end else if (digit == REC_S4) begin
              phase_nxt          = PH_SKIP;
              pending_status_nxt = ST_S4;
            end else begin
              phase_nxt          = PH_SKIP;
              pending_status_nxt = ST_SKIPPED;
            end
          end
        end
        PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM: begin
          if (!hex_ok) begin
            phase_nxt          = PH_SKIP;
            pending_status_nxt = ST_FORMAT;
          end else if (!nibble_half_r) begin
            high_nibble_nxt = hex_val;
            nibble_half_nxt = 1'b1;
          end else begin
            nibble_half_nxt = 1'b0;
            if (phase_r == PH_COUNT) begin
              byte_count_nxt  = byte_val;
              running_sum_nxt = byte_val;
              if (byte_val < ({5'd0, address_bytes_r} + 8'd1)) begin
                phase_nxt          = PH_SKIP;
                pending_status_nxt = ST_FORMAT;
              end else begin
                fields_left_nxt   = {5'd0, address_bytes_r};
                address_accum_nxt = 32'd0;
                phase_nxt         = PH_ADDR;
              end
            end else if (phase_r == PH_ADDR) begin
              address_accum_nxt = {address_accum_r[23:0], byte_val};
              running_sum_nxt   = sum_add;
              fields_left_nxt   = fields_dec;
              if (fields_dec == 8'd0) begin
                fields_left_nxt = byte_count_r - {5'd0, address_bytes_r} - 8'd1;
                data_index_nxt  = 8'd0;
                phase_nxt       = (fields_left_nxt != 8'd0) ? PH_DATA : PH_CSUM;
              end
            end else if (phase_r == PH_DATA) begin
              running_sum_nxt  = sum_add;
              emit             = 1'b1;
              res.kind         = KIND_DATA;
              res.data_byte    = byte_val;
              res.byte_address = address_accum_r + {24'd0, data_index_r};
              res.line_status  = ST_OK;
              data_index_nxt   = data_index_r + 8'd1;
              fields_left_nxt  = fields_dec;
              if (fields_dec == 8'd0) begin
                phase_nxt = PH_CSUM;
              end
            end else begin
              if (sum_add == SUM_GOOD) begin
                phase_nxt = PH_EOL;
              end else begin
                phase_nxt          = PH_SKIP;
                pending_status_nxt = ST_CHECKSUM;
              end
            end
          end
        end
        PH_EOL: begin
          // anything after a good checksum
          phase_nxt          = PH_SKIP;
          pending_status_nxt = ST_BYTECNT;
        end
        PH_SKIP: begin
          phase_nxt = PH_SKIP;
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_START;
      first_line_r     <= 1'b1;
      type_digit_r     <= 4'd0;
      address_bytes_r  <= 3'd0;
      high_nibble_r    <= 4'd0;
      nibble_half_r    <= 1'b0;
      byte_count_r     <= 8'd0;
      fields_left_r    <= 8'd0;
      address_accum_r  <= 32'd0;
      data_index_r     <= 8'd0;
      running_sum_r    <= 8'd0;
      pending_status_r <= ST_OK;
    end else if (in_acc) begin
      phase_r          <= phase_nxt;
      first_line_r     <= first_line_nxt;
      type_digit_r     <= type_digit_nxt;
      address_bytes_r  <= address_bytes_nxt;
      high_nibble_r    <= high_nibble_nxt;
      nibble_half_r    <= nibble_half_nxt;
      byte_count_r     <= byte_count_nxt;
      fields_left_r    <= fields_left_nxt;
      address_accum_r  <= address_accum_nxt;
      data_index_r     <= data_index_nxt;
      running_sum_r    <= running_sum_nxt;
      pending_status_r <= pending_status_nxt;
    end
  end

  // Output buffer: result register with a skid entry behind it.
  assign out_fire  = out_valid_r && !out_stall;
  assign res_valid = in_acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= skid_valid_r && res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
      if (res_valid) begin
        skid_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_data_byte    = out_r.data_byte;
  assign out_byte_address = out_r.byte_address;
  assign out_line_status  = out_r.line_status;
  assign out_record_digit = out_r.record_digit;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register empty");

  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == KIND_DATA |-> out_r.line_status == ST_OK)
    else $error("data result carries a nonzero status");

  a_eoi_new_file: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_input |=> phase_r == PH_START && first_line_r)
    else $error("end of input did not return to start of file");

  a_eol_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EOL |-> !nibble_half_r)
    else $error("half byte pending after checksum");

endmodule
